// ===== design/mhpq_pkg.sv =====
package mhpq_pkg;

  localparam int unsigned CapacityDefault = 64;
  localparam int unsigned KeyBitsDefault  = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_UPDATE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2,
    OP_SHL  = 2'd3
  } cell_op_e;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_APPLY = 5'b00100,
    S_REINS = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

endpackage

// ===== design/mhpq_cell.sv =====
module mhpq_cell import mhpq_pkg::*; #(
  parameter int unsigned KEY_BITS = KeyBitsDefault
) (
  input  logic                       clk_i,
  input  cell_op_e                   op_i,
  input  logic signed [KEY_BITS-1:0] key_i,
  input  logic                       valid_i,
  input  logic signed [KEY_BITS-1:0] left_val_i,
  input  logic                       left_le_i,
  input  logic signed [KEY_BITS-1:0] right_val_i,
  output logic signed [KEY_BITS-1:0] val_o,
  output logic                       le_o,
  output logic                       eq_o
);

  logic signed [KEY_BITS-1:0] val_q, val_d;
  logic                       ge;

  assign le_o = valid_i && (val_q <= key_i);
  assign ge   = valid_i && (val_q >= key_i);
  assign eq_o = valid_i && (val_q == key_i);
  assign val_o = val_q;

  always_comb begin
    unique case (op_i)
      OP_INS:  val_d = le_o ? val_q : (left_le_i ? key_i : left_val_i);
      OP_DEL:  val_d = ge ? right_val_i : val_q;
      OP_SHL:  val_d = right_val_i;
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== design/min_heap_priority_queue_core.sv =====
// channel  direction  handshake              payload
// in       input      in_valid_i/in_ready_o  cmd_i, key_i, new_key_i
// out      output     out_valid_o/out_ready_i status_o, head_key_o, entry_count_o
//
// keys sit sorted in a row of cells, smallest first; each cell compares locally
// and registers its own, its left or its right neighbor's key
// one item: after its transfer the core passes scan, apply, reinsert for an update
// that hits, and done, where the result loads; then it takes the next transfer
// reset clears the fill count and the control; cell contents need no reset
// a waiting result holds the core in done, so the next item waits for the result load
module min_heap_priority_queue_core import mhpq_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDefault,
  parameter int unsigned KEY_BITS = KeyBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] new_key_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] head_key_o,
  output logic [6:0]         entry_count_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e                     state_q, state_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  cmd_e                       cmd_q;
  logic signed [KEY_BITS-1:0] key_q, nkey_q, cell_key;
  status_e                    st_q, st_d;
  logic [CAPACITY-1:0]        eq_q, eq, le, valid;
  cell_op_e                   op;
  logic                       found, full, empty, load_out;
  logic                       out_valid_q;
  logic [1:0]                 status_q;
  logic signed [31:0]         head_q;
  logic [6:0]                 count_q;
  logic signed [KEY_BITS-1:0] vals [CAPACITY];

  assign in_ready_o = (state_q == S_IDLE);
  assign found = |eq_q;
  assign full  = (cnt_q == CW'(CAPACITY));
  assign empty = (cnt_q == '0);
  assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    st_d     = st_q;
    op       = OP_HOLD;
    cell_key = key_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_SCAN;
      S_SCAN:  state_d = S_APPLY;
      S_APPLY: begin
        state_d = S_DONE;
        unique case (cmd_q)
          CMD_INSERT: begin
            if (full) begin
              st_d = ST_FULL;
            end else begin
              st_d = ST_OK;
              op = OP_INS;
              cnt_d = cnt_q + 1'b1;
            end
          end
          CMD_REMOVE: begin
            if (empty) begin
              st_d = ST_EMPTY;
            end else begin
              st_d = ST_OK;
              op = OP_SHL;
              cnt_d = cnt_q - 1'b1;
            end
          end
          CMD_SEARCH: st_d = found ? ST_OK : ST_NOTFOUND;
          default: begin
            st_d = found ? ST_OK : ST_NOTFOUND;
            if (found) begin
              op = OP_DEL;
              cnt_d = cnt_q - 1'b1;
              state_d = S_REINS;
            end
          end
        endcase
      end
      S_REINS: begin
        op = OP_INS;
        cell_key = nkey_q;
        cnt_d = cnt_q + 1'b1;
        state_d = S_DONE;
      end
      default: if (load_out) state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= cmd_e'(cmd_i);
      key_q  <= KEY_BITS'(key_i);
      nkey_q <= KEY_BITS'(new_key_i);
    end
    if (state_q == S_SCAN) eq_q <= eq;
    st_q <= st_d;
    if (load_out) begin
      status_q <= st_q;
      head_q   <= empty ? 32'sd0 : 32'(vals[0]);
      count_q  <= 7'(cnt_q);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KEY_BITS-1:0] left_val, right_val;
    logic                       left_le;
    assign valid[i] = (CW'(i) < cnt_q);
    if (i == 0) begin : g_first
      assign left_val = cell_key;
      assign left_le  = 1'b1;
    end else begin : g_mid
      assign left_val = vals[i-1];
      assign left_le  = le[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_val = vals[i];
    end else begin : g_inner
      assign right_val = vals[i+1];
    end
    mhpq_cell #(.KEY_BITS(KEY_BITS)) u_cell (
      .clk_i       (clk_i),
      .op_i        (op),
      .key_i       (cell_key),
      .valid_i     (valid[i]),
      .left_val_i  (left_val),
      .left_le_i   (left_le),
      .right_val_i (right_val),
      .val_o       (vals[i]),
      .le_o        (le[i]),
      .eq_o        (eq[i])
    );
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign head_key_o    = head_q;
  assign entry_count_o = count_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("fill count above capacity");
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_SCAN))
    else $error("accepted item did not start a scan");
  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && cnt_q >= CW'(2)) |-> (vals[0] <= vals[1]))
    else $error("cell row out of order");
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && st_q == ST_EMPTY) |-> (cnt_q == '0))
    else $error("empty status with entries held");
`endif

endmodule
